// ===== hw/rtl/gcd_pkg.sv =====
// Package with constants, types and helper functions for the great circle distance block.
package gcd_pkg;

  localparam int CordicStagesDefault = 24;
  localparam logic [15:0] RadiusReset = 16'd6371;

  localparam logic signed [23:0] LatMax = 24'sd5898240;
  localparam logic signed [24:0] LonMax = 25'sd11796480;
  localparam logic signed [26:0] Deg90Q17 = 27'sd11796480;
  localparam logic signed [26:0] Deg180Q17 = 27'sd23592960;
  localparam logic [63:0] PiQ60 = 64'h3243F6A8885A308D;
  localparam logic [31:0] PiQ30 = 32'(((PiQ60 + 64'd536870912) >> 30));
  localparam logic [63:0] DegToRad = (PiQ60 / 64'd180) >> 17;
  localparam logic signed [33:0] GainInvQ30 = 34'sh026DD3B6A;
  localparam logic signed [33:0] OneQ30 = 34'sd1073741824;
  localparam logic [25:0] DistMax = 26'd52707072;

  // Data word carried along the angle rotation chain.
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } gcd_vec_t;

  // CORDIC arctangent table entry i in Q30.
  function automatic logic signed [33:0] gcd_atan(input int i);
    logic [63:0] v;
    logic signed [63:0] acc;
    logic [63:0] term;
    int sh;
    v = '0;
    acc = '0;
    if (i == 0) begin
      v = PiQ60;
    end else begin
      for (int k = 0; k < 32; k++) begin
        sh = i * (2 * k + 1);
        if (sh <= 62) begin
          term = (64'h4000000000000000 >> sh) / 64'(2 * k + 1);
          if (k % 2 == 1) acc = acc - $signed(term);
          else acc = acc + $signed(term);
        end
      end
      v = acc;
    end
    return 34'((v + 64'h80000000) >> 32);
  endfunction

endpackage

// ===== hw/rtl/great_circle_distance_top.sv =====
// Top level of the pipelined haversine great circle distance block.
//
// The block takes one request per clock and returns one result per request, in
// order. Each request passes a fixed pipeline: clamping and angle prep, four
// parallel rotation CORDIC chains of CORDIC_STAGES cells, three product stages,
// two 31-cell square root chains, a vectoring CORDIC chain of CORDIC_STAGES
// cells, a two-stage radius scaling and an output FIFO with a registered head.
// The sustained rate is one request per cycle while the output is not stalled,
// and the datapath never stops. Results are written into an output FIFO of
// 2*CORDIC_STAGES + 43 entries. A count of requests in flight and stored holds
// off the input before that FIFO could overflow, so a stalled output pushes
// back on the input once the stored results plus the requests in flight nearly
// fill the FIFO. When either point is invalid the distance is zero and
// points_invalid is set. The radius register should only be written while no
// request is in flight.
module great_circle_distance_top import gcd_pkg::*; #(
  parameter int CORDIC_STAGES = CordicStagesDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] first_latitude,
  input  logic signed [24:0] first_longitude,
  input  logic               first_valid,
  input  logic signed [23:0] second_latitude,
  input  logic signed [24:0] second_longitude,
  input  logic               second_valid,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [25:0]        distance_km,
  output logic               points_invalid
);

  // Cycles from the stage-0 register to the FIFO write.
  localparam int Depth = 2 * CORDIC_STAGES + 37;

  logic [15:0] radius;
  always_ff @(posedge clk) begin
    if (rst) radius <= RadiusReset;
    else if (cfg_write) radius <= cfg_data;
  end

  // The datapath registers have no enable, so the pipeline always advances.
  // A FIFO absorbs every result, and the input stalls when the requests in
  // flight plus those stored could overflow it. The spare entries beyond the
  // pipeline depth keep one request per cycle flowing when the output is free.
  localparam int FifoDepth = Depth + 6;
  localparam int Aw = $clog2(FifoDepth);

  logic [Aw:0] count;       // entries stored plus requests in flight
  logic        in_acc, out_acc;
  assign in_stall = count >= (Aw + 1)'(FifoDepth - 1);
  assign in_acc   = in_valid && !in_stall;

  // ---------------- stage 0: clamp and angle prep ----------------
  function automatic logic signed [23:0] clat(input logic signed [23:0] v);
    return (v > LatMax) ? LatMax : ((v < -LatMax) ? -LatMax : v);
  endfunction
  function automatic logic signed [24:0] clon(input logic signed [24:0] v);
    return (v > LonMax) ? LonMax : ((v < -LonMax) ? -LonMax : v);
  endfunction

  logic signed [26:0] p_lat1, p_lat2, p_hlat, p_hlon;
  logic               p_ok, p_vld;
  always_ff @(posedge clk) begin
    logic signed [26:0] l1, l2, h;
    l1 = 27'(clat(first_latitude));
    l2 = 27'(clat(second_latitude));
    h  = 27'(clon(second_longitude)) - 27'(clon(first_longitude));
    if (h > Deg90Q17) h = h - Deg180Q17;
    else if (h < -Deg90Q17) h = h + Deg180Q17;
    p_lat1 <= l1 <<< 1;
    p_lat2 <= l2 <<< 1;
    p_hlat <= l2 - l1;
    p_hlon <= h;
    p_ok   <= first_valid && second_valid;
  end
  always_ff @(posedge clk) begin
    if (rst) p_vld <= 1'b0;
    else p_vld <= in_acc;
  end

  // ---------------- stage 1: degrees to radians ----------------
  function automatic logic signed [33:0] to_rad(input logic signed [26:0] d);
    logic [26:0] m;
    logic [63:0] r;
    m = d[26] ? 27'(-d) : 27'(d);
    r = ({37'd0, m} * DegToRad + 64'd536870912) >> 30;
    return d[26] ? -34'(r) : 34'(r);
  endfunction

  gcd_vec_t rin [4];
  logic     r_ok;
  always_ff @(posedge clk) begin
    rin[0] <= '{x: GainInvQ30, y: '0, z: to_rad(p_lat1)};
    rin[1] <= '{x: GainInvQ30, y: '0, z: to_rad(p_lat2)};
    rin[2] <= '{x: GainInvQ30, y: '0, z: to_rad(p_hlat)};
    rin[3] <= '{x: GainInvQ30, y: '0, z: to_rad(p_hlon)};
    r_ok   <= p_ok;
  end

  // ---------------- rotation chains ----------------
  gcd_vec_t rch [4][CORDIC_STAGES+1];
  logic     okch [CORDIC_STAGES+1];
  assign okch[0] = r_ok;
  for (genvar c = 0; c < 4; c++) begin : g_rot
    assign rch[c][0] = rin[c];
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      logic side_o;
      gcd_rot_cell #(.Index(i), .Vectoring(1'b0), .SideWidth(1)) u_cell (
        .clk(clk), .vec_in(rch[c][i]), .side_in(okch[i]),
        .vec_out(rch[c][i+1]), .side_out(side_o)
      );
      if (c == 0) begin : g_side
        assign okch[i+1] = side_o;
      end
    end
  end

  // ---------------- products ----------------
  function automatic logic signed [33:0] mul30(input logic signed [33:0] a,
                                               input logic signed [33:0] b);
    logic signed [67:0] p;
    p = 68'(a) * 68'(b) + 68'sd536870912;
    return 34'(p >>> 30);
  endfunction

  logic signed [33:0] m_sl2, m_cc, m_sn2, a_sum;
  logic               m_ok, m_ok2, a_ok;
  always_ff @(posedge clk) begin
    m_sl2 <= mul30(rch[2][CORDIC_STAGES].y, rch[2][CORDIC_STAGES].y);
    m_cc  <= mul30(rch[0][CORDIC_STAGES].x, rch[1][CORDIC_STAGES].x);
    m_sn2 <= mul30(rch[3][CORDIC_STAGES].y, rch[3][CORDIC_STAGES].y);
    m_ok  <= okch[CORDIC_STAGES];
  end
  logic signed [33:0] m2_sl2, m2_prod;
  always_ff @(posedge clk) begin
    m2_sl2  <= m_sl2;
    m2_prod <= mul30(m_cc, m_sn2);
    m_ok2   <= m_ok;
  end
  always_ff @(posedge clk) begin
    logic signed [34:0] s;
    s = 35'(m2_sl2) + 35'(m2_prod);
    if (s < 0) a_sum <= '0;
    else if (s > 35'(OneQ30)) a_sum <= OneQ30;
    else a_sum <= 34'(s);
    a_ok <= m_ok2;
  end

  // ---------------- square root chains ----------------
  logic [61:0] sq_rem [2][32];
  logic [30:0] sq_root [2][32];
  logic        sq_ok [32];
  assign sq_rem[0][0]  = 62'({a_sum[30:0], 30'd0});
  assign sq_rem[1][0]  = 62'({31'(OneQ30 - a_sum), 30'd0});
  assign sq_root[0][0] = '0;
  assign sq_root[1][0] = '0;
  assign sq_ok[0]      = a_ok;
  for (genvar c = 0; c < 2; c++) begin : g_sq
    for (genvar i = 0; i < 31; i++) begin : g_cell
      logic side_o;
      gcd_sqrt_cell #(.Step(i), .SideWidth(1)) u_cell (
        .clk(clk), .rem_in(sq_rem[c][i]), .root_in(sq_root[c][i]), .side_in(sq_ok[i]),
        .rem_out(sq_rem[c][i+1]), .root_out(sq_root[c][i+1]), .side_out(side_o)
      );
      if (c == 0) begin : g_side
        assign sq_ok[i+1] = side_o;
      end
    end
  end

  // ---------------- vectoring chain ----------------
  gcd_vec_t vch [CORDIC_STAGES+1];
  logic     vok [CORDIC_STAGES+1];
  assign vch[0] = '{x: 34'(sq_root[1][31]), y: 34'(sq_root[0][31]), z: '0};
  assign vok[0] = sq_ok[31];
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
    gcd_rot_cell #(.Index(i), .Vectoring(1'b1), .SideWidth(1)) u_cell (
      .clk(clk), .vec_in(vch[i]), .side_in(vok[i]),
      .vec_out(vch[i+1]), .side_out(vok[i+1])
    );
  end

  // ---------------- scaling ----------------
  logic [31:0] ang;
  logic        ang_ok;
  always_ff @(posedge clk) begin
    logic signed [34:0] z2;
    z2 = 35'(vch[CORDIC_STAGES].z) <<< 1;
    if (z2 < 0) ang <= '0;
    else if (z2 > 35'(PiQ30)) ang <= PiQ30;
    else ang <= 32'(z2);
    ang_ok <= vok[CORDIC_STAGES];
  end
  logic [25:0] dist_q;
  logic        dist_ok;
  always_ff @(posedge clk) begin
    logic [47:0] d;
    d = ({16'd0, ang} * {32'd0, radius} + 48'd2097152) >> 22;
    dist_q  <= (d > 48'(DistMax)) ? DistMax : 26'(d);
    dist_ok <= ang_ok;
  end

  // Valid shift line that follows each request through the datapath.
  logic [Depth-1:0] vline;
  always_ff @(posedge clk) begin
    if (rst) vline <= '0;
    else vline <= {vline[Depth-2:0], p_vld};
  end

  // ---------------- output FIFO ----------------
  // The memory is read into a head register, which drives the result ports.
  logic [26:0]   fifo_mem [FifoDepth];
  logic [Aw-1:0] wp, rp;
  logic [Aw:0]   fill;      // entries held in the memory
  logic          wr, rd;
  logic [26:0]   head;
  logic          head_vld;
  assign wr = vline[Depth-1];
  assign rd = (fill != '0) && (!head_vld || out_acc);
  always_ff @(posedge clk) begin
    if (wr) fifo_mem[wp] <= {dist_ok ? dist_q : 26'd0, !dist_ok};
    if (rd) head <= fifo_mem[rp];
  end
  assign out_valid = head_vld;
  assign out_acc   = head_vld && !out_stall;
  assign {distance_km, points_invalid} = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; fill <= '0; count <= '0; head_vld <= 1'b0;
    end else begin
      if (wr) wp <= (wp == Aw'(FifoDepth - 1)) ? '0 : wp + 1'b1;
      if (rd) rp <= (rp == Aw'(FifoDepth - 1)) ? '0 : rp + 1'b1;
      if (rd) head_vld <= 1'b1;
      else if (out_acc) head_vld <= 1'b0;
      fill  <= fill + (Aw + 1)'(wr) - (Aw + 1)'(rd);
      count <= count + (Aw + 1)'(in_acc) - (Aw + 1)'(out_acc);
    end
  end

endmodule

// ===== hw/rtl/gcd_rot_cell.sv =====
// One rotation or vectoring CORDIC cell of the chain.
module gcd_rot_cell import gcd_pkg::*; #(
  parameter int Index = 0,
  parameter bit Vectoring = 1'b0,
  parameter int SideWidth = 1
) (
  input  logic                 clk,
  input  gcd_vec_t             vec_in,
  input  logic [SideWidth-1:0] side_in,
  output gcd_vec_t             vec_out,
  output logic [SideWidth-1:0] side_out
);

  localparam logic signed [33:0] Atan = gcd_atan(Index);

  gcd_vec_t vec_next;
  logic     dir_pos;
  logic signed [33:0] dx, dy;

  always_comb begin
    dx = vec_in.y >>> Index;
    dy = vec_in.x >>> Index;
    dir_pos = Vectoring ? !vec_in.y[33] : !vec_in.z[33];
    vec_next = vec_in;
    if (Vectoring) begin
      if (dir_pos) begin
        vec_next.x = vec_in.x + dx;
        vec_next.y = vec_in.y - dy;
        vec_next.z = vec_in.z + Atan;
      end else begin
        vec_next.x = vec_in.x - dx;
        vec_next.y = vec_in.y + dy;
        vec_next.z = vec_in.z - Atan;
      end
    end else begin
      if (dir_pos) begin
        vec_next.x = vec_in.x - dx;
        vec_next.y = vec_in.y + dy;
        vec_next.z = vec_in.z - Atan;
      end else begin
        vec_next.x = vec_in.x + dx;
        vec_next.y = vec_in.y - dy;
        vec_next.z = vec_in.z + Atan;
      end
    end
  end

  always_ff @(posedge clk) begin
    vec_out  <= vec_next;
    side_out <= side_in;
  end

endmodule

// ===== hw/rtl/gcd_sqrt_cell.sv =====
// One digit step of a pipelined integer square root.
module gcd_sqrt_cell import gcd_pkg::*; #(
  parameter int Step = 0,
  parameter int SideWidth = 1
) (
  input  logic                 clk,
  input  logic [61:0]          rem_in,
  input  logic [30:0]          root_in,
  input  logic [SideWidth-1:0] side_in,
  output logic [61:0]          rem_out,
  output logic [30:0]          root_out,
  output logic [SideWidth-1:0] side_out
);

  // Bit position 2*(30-Step); trial = (root << (31-Step)) | bit, root kept unshifted.
  localparam int Sh = 30 - Step;
  logic [63:0] trial;
  logic        take;

  always_comb begin
    trial = ({33'd0, root_in} << (Sh + 1)) | (64'd1 << (2 * Sh));
    take  = {2'b00, rem_in} >= trial;
  end

  always_ff @(posedge clk) begin
    rem_out  <= take ? 62'({2'b00, rem_in} - trial) : rem_in;
    root_out <= take ? (root_in | (31'd1 << Sh)) : root_in;
    side_out <= side_in;
  end

endmodule

// ===== hw/rtl/gcd_checker.sv =====
// Port-level assertions for the great circle distance block, bound to the top level.
module gcd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [25:0] distance_km,
  input logic        points_invalid
);

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && points_invalid |-> distance_km == '0)
    else $error("invalid request gave a nonzero distance");

  a_dist_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> distance_km <= 26'd52707072)
    else $error("distance above the largest possible value");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(distance_km))
    else $error("stalled result changed");

  a_no_early: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

endmodule

bind great_circle_distance_top gcd_checker u_gcd_checker (
  .clk(clk), .rst(rst),
  .out_valid(out_valid), .out_stall(out_stall),
  .distance_km(distance_km), .points_invalid(points_invalid)
);
